@@ rtl/core/rau_pkg.sv @@
// Shared constants, opcodes and controller/datapath command types for the rational unit.
package rau_pkg;

   // Operand bits actually used; inputs are sign-extended from the top bit.
   localparam int OPERAND_WIDTH = 32;
   // Widths of the port fields, fixed by the interface.
   localparam int PORT_W = 32;
   localparam int RES_W  = 64;
   localparam int OP_W   = 3;
   // Full product of two operands.
   localparam int PROD_W = 2 * OPERAND_WIDTH;
   // Counter width for one pass over the operand bits.
   localparam int CNT_W  = $clog2(OPERAND_WIDTH);

   typedef enum logic [OP_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_CMP = 3'd4,
      OP_RED = 3'd5
   } rau_op_type;

   // Which of the three products the shared multiplier forms this cycle.
   typedef enum logic [1:0] {
      PROD_P = 2'd0,
      PROD_Q = 2'd1,
      PROD_R = 2'd2
   } rau_prod_type;

   typedef struct packed {
      logic         load;
      logic         mul_en;
      rau_prod_type prod;
      logic         combine;
      logic         gcd_step;
      logic         div_init;
      logic         div_step;
      logic         red_fin;
      logic         out_load;
   } rau_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            gcd_done;
   } rau_status_type;

endpackage

@@ rtl/core/rau_if.sv @@
// Valid/ready channel interfaces for the request and response words.
interface rau_req_if;
   logic                                valid;
   logic                                ready;
   logic [rau_pkg::OP_W-1:0]            op;
   logic signed [rau_pkg::PORT_W-1:0]   a_num;
   logic signed [rau_pkg::PORT_W-1:0]   a_den;
   logic signed [rau_pkg::PORT_W-1:0]   b_num;
   logic signed [rau_pkg::PORT_W-1:0]   b_den;

   modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
   modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [rau_pkg::RES_W-1:0]   res_num;
   logic signed [rau_pkg::RES_W-1:0]   res_den;
   logic                               is_less;
   logic                               is_equal;
   logic                               is_greater;
   logic                               overflow;

   modport source (output valid, res_num, res_den, is_less, is_equal, is_greater, overflow,
                   input ready);
   modport sink (input valid, res_num, res_den, is_less, is_equal, is_greater, overflow,
                 output ready);
endinterface

@@ rtl/core/rau_datapath.sv @@
// Datapath: operand registers, shared multiplier, adder/comparator, binary gcd and dividers.
module rau_datapath (
   input  logic                              clock,
   input  logic [rau_pkg::OP_W-1:0]          in_op,
   input  logic signed [rau_pkg::PORT_W-1:0] in_a_num,
   input  logic signed [rau_pkg::PORT_W-1:0] in_a_den,
   input  logic signed [rau_pkg::PORT_W-1:0] in_b_num,
   input  logic signed [rau_pkg::PORT_W-1:0] in_b_den,
   input  rau_pkg::rau_cmd_type              cmd,
   output rau_pkg::rau_status_type           status,
   output logic signed [rau_pkg::RES_W-1:0]  out_res_num,
   output logic signed [rau_pkg::RES_W-1:0]  out_res_den,
   output logic                              out_is_less,
   output logic                              out_is_equal,
   output logic                              out_is_greater,
   output logic                              out_overflow
);
   import rau_pkg::*;

   localparam int OW = OPERAND_WIDTH;

   typedef logic signed [OW-1:0]    opd_type;
   typedef logic [OW-1:0]           mag_type;
   typedef logic signed [RES_W-1:0] res_type;

   function automatic mag_type magnitude(input opd_type v);
      magnitude = v[OW-1] ? mag_type'(-v) : mag_type'(v);
   endfunction

   // Captured operands, truncated to the operand width.
   logic [OP_W-1:0] op_ff;
   opd_type         an_ff, ad_ff, bn_ff, bd_ff;
   opd_type         an_in, ad_in, bn_in, bd_in;

   assign an_in = in_a_num[OW-1:0];
   assign ad_in = in_a_den[OW-1:0];
   assign bn_in = in_b_num[OW-1:0];
   assign bd_in = in_b_den[OW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= in_op;
         an_ff <= an_in;
         ad_ff <= ad_in;
         bn_ff <= bn_in;
         bd_ff <= bd_in;
      end
   end

   // Shared multiplier; operands depend on the opcode and on which product is due.
   opd_type                   mul_x, mul_y;
   logic signed [PROD_W-1:0]  prod;
   res_type                   pp_ff, pq_ff, pr_ff;

   always_comb begin
      mul_x = an_ff;
      mul_y = bd_ff;
      case (cmd.prod)
         PROD_P: begin
            mul_x = an_ff;
            mul_y = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         PROD_Q: begin
            mul_x = bn_ff;
            mul_y = ad_ff;
         end
         PROD_R: begin
            mul_x = ad_ff;
            mul_y = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_x = an_ff;
            mul_y = bd_ff;
         end
      endcase
   end

   assign prod = mul_x * mul_y;

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.prod)
            PROD_P:  pp_ff <= RES_W'(prod);
            PROD_Q:  pq_ff <= RES_W'(prod);
            PROD_R:  pr_ff <= RES_W'(prod);
            default: pr_ff <= RES_W'(prod);
         endcase
      end
   end

   // Adder for add/subtract, comparators for compare; equal denominators bypass products.
   logic    eq_den;
   logic    is_sub;
   res_type an64, ad64, bn64;
   res_type opx, opy, sum;
   logic    ovf;
   logic    cmp_lt, cmp_eq, cmp_gt;

   assign eq_den = (ad_ff == bd_ff);
   assign is_sub = (op_ff == OP_SUB);
   assign an64   = RES_W'(an_ff);
   assign ad64   = RES_W'(ad_ff);
   assign bn64   = RES_W'(bn_ff);
   assign opx    = eq_den ? an64 : pp_ff;
   assign opy    = eq_den ? bn64 : pq_ff;
   assign sum    = opx + (is_sub ? ~opy : opy) + res_type'(is_sub);
   assign ovf    = is_sub ? ((opx[RES_W-1] ^ opy[RES_W-1]) & (sum[RES_W-1] ^ opx[RES_W-1]))
                          : (~(opx[RES_W-1] ^ opy[RES_W-1]) & (sum[RES_W-1] ^ opx[RES_W-1]));
   assign cmp_lt = (opx < opy);
   assign cmp_eq = (opx == opy);
   assign cmp_gt = (opx > opy);

   // Binary gcd on the magnitudes of a; one step a cycle until one side reaches zero.
   mag_type           gx_ff, gy_ff;
   logic [CNT_W-1:0]  gk_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         gx_ff <= magnitude(an_in);
         gy_ff <= magnitude(ad_in);
         gk_ff <= '0;
      end else if (cmd.gcd_step) begin
         case ({gx_ff[0], gy_ff[0]})
            2'b00: begin
               gx_ff <= gx_ff >> 1;
               gy_ff <= gy_ff >> 1;
               gk_ff <= gk_ff + CNT_W'(1);
            end
            2'b01: gx_ff <= gx_ff >> 1;
            2'b10: gy_ff <= gy_ff >> 1;
            default: begin
               if (gx_ff >= gy_ff) begin
                  gx_ff <= (gx_ff - gy_ff) >> 1;
               end else begin
                  gy_ff <= (gy_ff - gx_ff) >> 1;
               end
            end
         endcase
      end
   end

   assign status = '{op: op_ff, gcd_done: ((gx_ff == '0) || (gy_ff == '0))};

   // Two restoring dividers share the gcd as divisor, one quotient bit a cycle each.
   mag_type         g_ff;
   mag_type         nq_ff, dq_ff;
   logic [OW:0]     nr_ff, dr_ff;
   logic [OW:0]     nt, dt;
   logic            n_ge, d_ge;

   assign nt   = {nr_ff[OW-1:0], nq_ff[OW-1]};
   assign dt   = {dr_ff[OW-1:0], dq_ff[OW-1]};
   assign n_ge = (nt >= {1'b0, g_ff});
   assign d_ge = (dt >= {1'b0, g_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         g_ff  <= (gx_ff | gy_ff) << gk_ff;
         nq_ff <= magnitude(an_ff);
         dq_ff <= magnitude(ad_ff);
         nr_ff <= '0;
         dr_ff <= '0;
      end else if (cmd.div_step) begin
         nr_ff <= n_ge ? (nt - {1'b0, g_ff}) : nt;
         dr_ff <= d_ge ? (dt - {1'b0, g_ff}) : dt;
         nq_ff <= {nq_ff[OW-2:0], n_ge};
         dq_ff <= {dq_ff[OW-2:0], d_ge};
      end
   end

   // Quotients take back the signs of the original numerator and denominator.
   opd_type red_num, red_den;
   logic    g_zero;

   assign g_zero  = (g_ff == '0);
   assign red_num = an_ff[OW-1] ? opd_type'(-nq_ff) : opd_type'(nq_ff);
   assign red_den = ad_ff[OW-1] ? opd_type'(-dq_ff) : opd_type'(dq_ff);

   // Staged result, moved to the output register once that is free.
   res_type st_num_ff, st_den_ff;
   logic    st_lt_ff, st_eq_ff, st_gt_ff, st_ov_ff;
   res_type st_num_in, st_den_in;
   logic    st_lt_in, st_eq_in, st_gt_in, st_ov_in;

   always_comb begin
      st_num_in = st_num_ff;
      st_den_in = st_den_ff;
      st_lt_in  = st_lt_ff;
      st_eq_in  = st_eq_ff;
      st_gt_in  = st_gt_ff;
      st_ov_in  = st_ov_ff;
      if (cmd.combine) begin
         st_num_in = '0;
         st_den_in = '0;
         st_lt_in  = 1'b0;
         st_eq_in  = 1'b0;
         st_gt_in  = 1'b0;
         st_ov_in  = 1'b0;
         case (op_ff)
            OP_ADD, OP_SUB: begin
               st_num_in = sum;
               st_den_in = eq_den ? ad64 : pr_ff;
               st_ov_in  = ~eq_den & ovf;
            end
            OP_MUL, OP_DIV: begin
               st_num_in = pp_ff;
               st_den_in = pr_ff;
            end
            OP_CMP: begin
               st_lt_in = cmp_lt;
               st_eq_in = cmp_eq;
               st_gt_in = cmp_gt;
            end
            default: begin
               st_num_in = '0;
            end
         endcase
      end else if (cmd.red_fin) begin
         st_num_in = g_zero ? an64 : RES_W'(red_num);
         st_den_in = g_zero ? ad64 : RES_W'(red_den);
         st_lt_in  = 1'b0;
         st_eq_in  = 1'b0;
         st_gt_in  = 1'b0;
         st_ov_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      st_num_ff <= st_num_in;
      st_den_ff <= st_den_in;
      st_lt_ff  <= st_lt_in;
      st_eq_ff  <= st_eq_in;
      st_gt_ff  <= st_gt_in;
      st_ov_ff  <= st_ov_in;
   end

   // Output register holds the response word while the next item is worked on.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_res_num    <= st_num_ff;
         out_res_den    <= st_den_ff;
         out_is_less    <= st_lt_ff;
         out_is_equal   <= st_eq_ff;
         out_is_greater <= st_gt_ff;
         out_overflow   <= st_ov_ff;
      end
   end

endmodule

@@ rtl/core/rau_ctrl.sv @@
// Controller state machine: sequences products, gcd, division and the output handoff.
module rau_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rau_pkg::rau_cmd_type    cmd,
   input  rau_pkg::rau_status_type status
);
   import rau_pkg::*;

   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(OPERAND_WIDTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_COMB,
      S_GCD,
      S_DIV,
      S_RFIN,
      S_HOLD
   } state_type;

   state_type        state_ff, state_in;
   rau_prod_type     prod_ff, prod_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             out_valid_ff, out_valid_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      prod_in  = prod_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.prod = prod_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               prod_in  = PROD_P;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (status.op == OP_RED) begin
               state_in = S_GCD;
            end else begin
               cmd.mul_en = 1'b1;
               case (prod_ff)
                  PROD_P:  prod_in = PROD_Q;
                  PROD_Q:  prod_in = PROD_R;
                  default: state_in = S_COMB;
               endcase
            end
         end
         S_COMB: begin
            cmd.combine = 1'b1;
            state_in    = S_HOLD;
         end
         S_GCD: begin
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               cnt_in       = '0;
               state_in     = S_DIV;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST) begin
               state_in = S_RFIN;
            end
         end
         S_RFIN: begin
            cmd.red_fin = 1'b1;
            state_in    = S_HOLD;
         end
         S_HOLD: begin
            if (!out_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid_in = cmd.out_load | (out_valid_ff & ~rsp_ready);

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         prod_ff      <= PROD_P;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prod_ff      <= prod_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   // A new word never overwrites one that has not been taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!out_valid_ff || rsp_ready))
      else $error("output register loaded while holding an untaken word");

   // A loaded word is presented on the next cycle.
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> out_valid_ff)
      else $error("loaded word not presented");

   // Reduce finishes only after a full division pass.
   a_rfin_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RFIN |-> ($past(state_ff) == S_DIV && $past(cnt_ff) == DIV_LAST))
      else $error("reduce finished before the division completed");

   // Result-writing commands never collide.
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.combine, cmd.red_fin, cmd.out_load}))
      else $error("conflicting datapath commands");

endmodule

@@ rtl/core/rational_arithmetic_unit_core.sv @@
// Top level of the rational arithmetic unit: controller, datapath and channel ports.
//
// Each request word carries two signed fractions and an opcode (add, subtract, multiply,
// divide, compare, reduce) and yields exactly one response word. One word is worked on
// at a time. Add, subtract, multiply, divide and compare form three products on a single
// shared 32x32 multiplier, one per cycle, then combine them. Reduce runs a binary gcd,
// one step per cycle, followed by two restoring dividers that deliver one quotient bit
// per cycle. The response sits in an output register, so a new request word is taken
// while the previous response still waits to be read.
module rational_arithmetic_unit_core (
   input logic  clock,
   input logic  reset,
   rau_req_if.sink   req_bus,
   rau_rsp_if.source rsp_bus
);
   import rau_pkg::*;

   rau_cmd_type    cmd;
   rau_status_type status;
   logic           req_ready;
   logic           rsp_valid;

   // Sequencer.
   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic.
   rau_datapath u_datapath (
      .clock          (clock),
      .in_op          (req_bus.op),
      .in_a_num       (req_bus.a_num),
      .in_a_den       (req_bus.a_den),
      .in_b_num       (req_bus.b_num),
      .in_b_den       (req_bus.b_den),
      .cmd            (cmd),
      .status         (status),
      .out_res_num    (rsp_bus.res_num),
      .out_res_den    (rsp_bus.res_den),
      .out_is_less    (rsp_bus.is_less),
      .out_is_equal   (rsp_bus.is_equal),
      .out_is_greater (rsp_bus.is_greater),
      .out_overflow   (rsp_bus.overflow)
   );

   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

endmodule
